>>> design/cartridge_bank_controller_with_rtc_macros.svh
// Assertion macros for the checker of the bank controller.
`ifndef CARTRIDGE_BANK_CONTROLLER_WITH_RTC_MACROS_SVH
`define CARTRIDGE_BANK_CONTROLLER_WITH_RTC_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CBC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define CBC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/cbcrtc_pkg.sv
// Package: types, constants and bank lookup tables for the bank controller.
`default_nettype none

package cbcrtc_pkg;

    // Bank counts of the cartridge
    localparam int RAM_BANK_COUNT = 4;
    localparam int ROM_BANK_COUNT = 128;

    // Banked RAM geometry: four 8 KiB banks addressed by a 15-bit index
    localparam int RAM_OFFSET_W = 13;
    localparam int RAM_INDEX_W  = 15;
    localparam int RAM_DEPTH    = 1 << RAM_INDEX_W;

    // Stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;

    // Access kinds carried on s_tuser
    typedef enum logic [1:0] {
        KIND_ROM_READ = 2'd0,
        KIND_RAM_READ = 2'd1,
        KIND_WRITE    = 2'd2
    } kind_t;

    // RAM/clock select codes for the clock registers
    localparam logic [7:0] SEL_SECONDS  = 8'h08;
    localparam logic [7:0] SEL_MINUTES  = 8'h09;
    localparam logic [7:0] SEL_HOURS    = 8'h0A;
    localparam logic [7:0] SEL_DAYS_LO  = 8'h0B;
    localparam logic [7:0] SEL_DAYS_HI  = 8'h0C;

    localparam logic [7:0] DAYS_HI_MASK = 8'hC1;
    localparam logic [7:0] OPEN_BUS     = 8'hFF;
    localparam logic [3:0] ENABLE_CODE  = 4'hA;

    // Bank folding tables: entry i holds i modulo the bank count
    typedef logic [127:0][6:0] rom_lut_t;
    typedef logic [3:0][1:0]   ram_lut_t;

    function automatic rom_lut_t make_rom_lut();
        rom_lut_t lut;
        int       r;
        r = 0;
        for (int i = 0; i < 128; i++) begin
            lut[i] = 7'(r);
            r++;
            if (r == ROM_BANK_COUNT) begin
                r = 0;
            end
        end
        return lut;
    endfunction

    function automatic ram_lut_t make_ram_lut();
        ram_lut_t lut;
        int       r;
        r = 0;
        for (int i = 0; i < 4; i++) begin
            lut[i] = 2'(r);
            r++;
            if (r == RAM_BANK_COUNT) begin
                r = 0;
            end
        end
        return lut;
    endfunction

    localparam rom_lut_t ROM_BANK_LUT = make_rom_lut();
    localparam ram_lut_t RAM_BANK_LUT = make_ram_lut();

endpackage

`default_nettype wire

>>> design/cartridge_bank_controller_with_rtc.sv
// Top level: cartridge bank controller with clock registers and banked RAM.
`default_nettype none

// Each bus access is handled in two steps: when it is accepted the banked RAM is read at
// the addressed entry, and when it completes the result is formed, the control registers
// and the RAM are updated and the result beat is loaded into the output register. The
// registered read port of the RAM sets this: s_tready is low while an access is held for
// completion, and it stays low only longer while the output register is full and not
// taken. A finished result may wait on m_tready while the next access is accepted. The
// RAM needs no clearing after reset; reading a never-written entry gives an unspecified
// byte. cfg_wen/cfg_wdata set the has-timer bit and are meant for use while idle.
module cartridge_bank_controller_with_rtc
    import cbcrtc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration: has-timer bit
    input  wire logic                 cfg_wen,
    input  wire logic                 cfg_wdata,
    // access stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // address[15:0], write_data[23:16]
    input  wire logic [S_TUSER_W-1:0] s_tuser,  // kind[1:0]
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata   // read_data[7:0], rom_address[28:8],
                                                // ram_enabled[29], ram_dirty[30], zero[31]
);

    // Control and bank registers
    logic        has_timer_reg,  has_timer_next;
    logic        enable_reg,     enable_next;
    logic [6:0]  rom_sel_reg,    rom_sel_next;
    logic [7:0]  ram_sel_reg,    ram_sel_next;
    logic        latch_reg,      latch_next;
    logic        dirty_reg,      dirty_next;
    logic        busy_reg,       busy_next;
    logic        m_valid_reg,    m_valid_next;

    // Clock and latched clock registers
    logic [5:0]  sec_reg,  sec_next;
    logic [5:0]  min_reg,  min_next;
    logic [4:0]  hour_reg, hour_next;
    logic [15:0] day_reg,  day_next;
    logic [5:0]  hsec_reg,  hsec_next;
    logic [5:0]  hmin_reg,  hmin_next;
    logic [4:0]  hhour_reg, hhour_next;
    logic [15:0] hday_reg,  hday_next;

    // Item held until the access completes
    logic [1:0]  kind_reg;
    logic [15:0] addr_reg;
    logic [7:0]  wdata_reg;

    // Output payload
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    // Banked RAM
    logic [7:0]             ram_mem [RAM_DEPTH];
    logic [7:0]             ram_rdata_reg;
    logic [RAM_INDEX_W-1:0] ram_rd_index;
    logic [RAM_INDEX_W-1:0] ram_wr_index;
    logic                   ram_we;

    logic        s_fire;
    logic        done;
    logic        in_ram_window;
    logic        ram_sel_low;
    logic [6:0]  rom_bank;
    logic [20:0] rom_addr;
    logic [7:0]  rd_data;

    assign s_tready = !busy_reg;
    assign s_fire   = s_tvalid && !busy_reg;
    assign done     = busy_reg && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // RAM indexes: bank from the select byte, offset from the address
    assign ram_rd_index = {RAM_BANK_LUT[ram_sel_reg[1:0]], s_tdata[RAM_OFFSET_W-1:0]};
    assign ram_wr_index = {RAM_BANK_LUT[ram_sel_reg[1:0]], addr_reg[RAM_OFFSET_W-1:0]};

    assign in_ram_window = (addr_reg[15:13] == 3'b101);
    assign ram_sel_low   = (ram_sel_reg[7:2] == 6'd0);

    // ROM mapping: bank 0 reads as bank 1, then folded to the bank count
    always_comb begin
        rom_bank = ROM_BANK_LUT[(rom_sel_reg == 7'd0) ? 7'd1 : rom_sel_reg];
        case (addr_reg[15:14])
            2'b00:   rom_addr = {5'd0, addr_reg};
            2'b01:   rom_addr = {rom_bank, addr_reg[13:0]};
            default: rom_addr = 21'd0;
        endcase
    end

    // RAM window read data
    always_comb begin
        rd_data = OPEN_BUS;
        if (in_ram_window && enable_reg) begin
            if (ram_sel_low) begin
                rd_data = ram_rdata_reg;
            end else if (has_timer_reg && latch_reg) begin
                case (ram_sel_reg)
                    SEL_SECONDS: rd_data = {2'd0, hsec_reg};
                    SEL_MINUTES: rd_data = {2'd0, hmin_reg};
                    SEL_HOURS:   rd_data = {3'd0, hhour_reg};
                    SEL_DAYS_LO: rd_data = hday_reg[7:0];
                    SEL_DAYS_HI: rd_data = hday_reg[15:8];
                    default:     rd_data = OPEN_BUS;
                endcase
            end
        end
    end

    // State update when the held access completes; the has-timer bit follows cfg_wen
    always_comb begin
        has_timer_next = cfg_wen ? cfg_wdata : has_timer_reg;
        enable_next    = enable_reg;
        rom_sel_next   = rom_sel_reg;
        ram_sel_next   = ram_sel_reg;
        latch_next     = latch_reg;
        dirty_next     = dirty_reg;
        sec_next       = sec_reg;
        min_next       = min_reg;
        hour_next      = hour_reg;
        day_next       = day_reg;
        hsec_next      = hsec_reg;
        hmin_next      = hmin_reg;
        hhour_next     = hhour_reg;
        hday_next      = hday_reg;
        ram_we         = 1'b0;
        if (done && kind_reg == KIND_WRITE) begin
            case (addr_reg[15:13])
                3'b000: begin
                    enable_next = (wdata_reg[3:0] == ENABLE_CODE);
                end
                3'b001: begin
                    rom_sel_next = wdata_reg[6:0];
                end
                3'b010: begin
                    ram_sel_next = wdata_reg;
                end
                3'b011: begin
                    if (has_timer_reg) begin
                        if (!latch_reg && wdata_reg == 8'd1) begin
                            hsec_next  = sec_reg;
                            hmin_next  = min_reg;
                            hhour_next = hour_reg;
                            hday_next  = day_reg;
                        end
                        latch_next = (wdata_reg == 8'd1);
                    end
                end
                3'b101: begin
                    if (enable_reg) begin
                        dirty_next = 1'b1;
                        if (ram_sel_low) begin
                            ram_we = 1'b1;
                        end else if (has_timer_reg) begin
                            case (ram_sel_reg)
                                SEL_SECONDS: sec_next  = wdata_reg[5:0];
                                SEL_MINUTES: min_next  = wdata_reg[5:0];
                                SEL_HOURS:   hour_next = wdata_reg[4:0];
                                SEL_DAYS_LO: day_next  = {day_reg[15:8], wdata_reg};
                                SEL_DAYS_HI: day_next  = {wdata_reg & DAYS_HI_MASK,
                                                          day_reg[7:0]};
                                default:     day_next  = day_reg;
                            endcase
                        end
                    end
                end
                default: begin
                    dirty_next = dirty_reg;
                end
            endcase
        end
    end

    // Handshake and result beat
    always_comb begin
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (done) begin
            busy_next    = 1'b0;
            m_valid_next = 1'b1;
            m_data_next  = {1'b0, dirty_next, enable_next,
                            (kind_reg == KIND_ROM_READ) ? rom_addr : 21'd0,
                            (kind_reg == KIND_RAM_READ) ? rd_data : OPEN_BUS};
        end
        if (s_fire) begin
            busy_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has_timer_reg <= 1'b1;
            enable_reg    <= 1'b0;
            rom_sel_reg   <= 7'd1;
            ram_sel_reg   <= 8'd0;
            latch_reg     <= 1'b0;
            dirty_reg     <= 1'b0;
            busy_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            sec_reg       <= 6'd0;
            min_reg       <= 6'd0;
            hour_reg      <= 5'd0;
            day_reg       <= 16'd0;
            hsec_reg      <= 6'd0;
            hmin_reg      <= 6'd0;
            hhour_reg     <= 5'd0;
            hday_reg      <= 16'd0;
        end else begin
            has_timer_reg <= has_timer_next;
            enable_reg    <= enable_next;
            rom_sel_reg   <= rom_sel_next;
            ram_sel_reg   <= ram_sel_next;
            latch_reg     <= latch_next;
            dirty_reg     <= dirty_next;
            busy_reg      <= busy_next;
            m_valid_reg   <= m_valid_next;
            sec_reg       <= sec_next;
            min_reg       <= min_next;
            hour_reg      <= hour_next;
            day_reg       <= day_next;
            hsec_reg      <= hsec_next;
            hmin_reg      <= hmin_next;
            hhour_reg     <= hhour_next;
            hday_reg      <= hday_next;
        end
    end

    // Held access and output payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg  <= s_tuser;
            addr_reg  <= s_tdata[15:0];
            wdata_reg <= s_tdata[23:16];
        end
        m_data_reg <= m_data_next;
    end

    // Banked RAM: read on accept, write on completion; never the same cycle
    always_ff @(posedge aclk) begin
        if (ram_we) begin
            ram_mem[ram_wr_index] <= wdata_reg;
        end
        if (s_fire) begin
            ram_rdata_reg <= ram_mem[ram_rd_index];
        end
    end

endmodule

`default_nettype wire

>>> design/cbcrtc_checker.sv
// Checker on the ports of the bank controller, bound to the top level.
`default_nettype none

`include "cartridge_bank_controller_with_rtc_macros.svh"

module cbcrtc_checker
    import cbcrtc_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result beat holds its payload
    `CBC_ASSERT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat dropped or changed while stalled")

    // A beat is never both a RAM read byte and a ROM address
    `CBC_ASSERT(a_one_source, aclk, aresetn, m_tvalid |-> (m_tdata[7:0] == OPEN_BUS || m_tdata[28:8] == 21'd0), "read data and ROM address both set")

    // One access in flight: after an accept the input side closes
    `CBC_ASSERT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second access accepted while one is in flight")

    // Reset empties the output register
    `CBC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result beat present after reset")

endmodule

bind cartridge_bank_controller_with_rtc cbcrtc_checker u_cbcrtc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
